FILE: sv/blms_pkg.sv
package blms_pkg;

    // Matrix geometry.
    localparam int ROWS  = 8;
    localparam int PINS  = 8;
    localparam int ROW_W = 3;
    localparam int PIN_W = 3;
    localparam int BTN_W = ROW_W + PIN_W;
    localparam int NUM_BUTTONS = ROWS * PINS;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Reset level of a stored button row (all released).
    localparam logic [PINS-1:0] BUTTON_ROW_RESET = 8'hFF;

    // Input operation codes.
    localparam logic [2:0] OP_PREPARE   = 3'd0;
    localparam logic [2:0] OP_SAMPLE    = 3'd1;
    localparam logic [2:0] OP_SET_LED   = 3'd2;
    localparam logic [2:0] OP_WRITE_ROW = 3'd3;
    localparam logic [2:0] OP_DRAIN     = 3'd4;
    localparam logic [2:0] OP_READ_ROW  = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_DRIVE    = 2'd0;
    localparam logic [1:0] KIND_EVENT    = 2'd1;
    localparam logic [1:0] KIND_READBACK = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ROWSEL_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_COLUMN_ENABLE      = 3'd1;
    localparam logic [2:0] CFG_BUTTON_ENABLE      = 3'd2;
    localparam logic [2:0] CFG_ROWSEL_INVERT_MASK = 3'd3;
    localparam logic [2:0] CFG_COLUMN_INVERT_MASK = 3'd4;
    localparam logic [2:0] CFG_DEBOUNCE_DELAY     = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] din_byte;
        logic [5:0] led_index;
        logic       led_value;
        logic [2:0] row_index;
        logic [7:0] row_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       rowsel_valid;
        logic [7:0] rowsel_byte;
        logic       column_valid;
        logic [7:0] column_byte;
        logic [5:0] button_number;
        logic       button_value;
        logic [7:0] button_row_out;
        logic [7:0] led_row_out;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       rowsel_enable;
        logic       column_enable;
        logic       button_enable;
        logic [7:0] rowsel_invert_mask;
        logic [7:0] column_invert_mask;
        logic [7:0] debounce_reload;
    } cfg_t;

    // Commands passed from the front to the back.
    typedef enum logic [2:0] {
        CMD_PREPARE,
        CMD_SAMPLE,
        CMD_SET_LED,
        CMD_WRITE_ROW,
        CMD_DRAIN,
        CMD_READ_ROW
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [ROW_W-1:0] row;
        logic [PINS-1:0]  data;
        logic             bit_value;
    } cmd_item_t;

    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } back_state_t;

endpackage

FILE: sv/blms_front.sv
module blms_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  blms_pkg::in_item_t   in_data,
    input  logic                 queue_full,
    output logic                 push,
    output blms_pkg::cmd_item_t  push_data
);
    import blms_pkg::*;

    logic known_op;

    // Decode the operation into a back-end command with its operands.
    always_comb
    begin
        known_op            = 1'b1;
        push_data           = '0;
        push_data.cmd       = CMD_PREPARE;
        unique case (in_data.op)
            OP_PREPARE:
            begin
                push_data.cmd = CMD_PREPARE;
            end
            OP_SAMPLE:
            begin
                push_data.cmd  = CMD_SAMPLE;
                push_data.data = in_data.din_byte;
            end
            OP_SET_LED:
            begin
                push_data.cmd       = CMD_SET_LED;
                push_data.row       = in_data.led_index[BTN_W-1:PIN_W];
                push_data.data      = PINS'(1) << in_data.led_index[PIN_W-1:0];
                push_data.bit_value = in_data.led_value;
            end
            OP_WRITE_ROW:
            begin
                push_data.cmd  = CMD_WRITE_ROW;
                push_data.row  = in_data.row_index;
                push_data.data = in_data.row_byte;
            end
            OP_DRAIN:
            begin
                push_data.cmd = CMD_DRAIN;
            end
            OP_READ_ROW:
            begin
                push_data.cmd = CMD_READ_ROW;
                push_data.row = in_data.row_index;
            end
            default:
            begin
                // Unused codes are accepted and dropped.
                known_op = 1'b0;
            end
        endcase
    end

    // Items are taken whenever the queue has room.
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full && known_op;

endmodule

FILE: sv/blms_queue.sv
module blms_queue #(
    parameter int DEPTH = blms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  blms_pkg::cmd_item_t  push_data,
    input  logic                 pop,
    output blms_pkg::cmd_item_t  head,
    output logic                 empty,
    output logic                 full
);
    import blms_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_item_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

endmodule

FILE: sv/blms_back.sv
module blms_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  blms_pkg::cfg_t       cfg,
    input  blms_pkg::cmd_item_t  head,
    input  logic                 queue_empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output blms_pkg::out_item_t  out_data
);
    import blms_pkg::*;

    back_state_t            state_reg, state_next;
    logic [ROW_W-1:0]       current_row_reg, current_row_next;
    logic [7:0]             debounce_reg, debounce_next;
    logic [PINS-1:0]        led_rows_reg [ROWS];
    logic [PINS-1:0]        led_rows_next [ROWS];
    logic [PINS-1:0]        button_rows_reg [ROWS];
    logic [PINS-1:0]        button_rows_next [ROWS];
    logic [NUM_BUTTONS-1:0] pending_reg, pending_next;
    logic [BTN_W-1:0]       drain_idx_reg, drain_idx_next;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic                   slot_free;
    logic                   load;
    out_item_t              result;
    logic [ROW_W-1:0]       rd_row;
    logic [PINS-1:0]        led_rd;
    logic [PINS-1:0]        btn_rd;
    logic [PINS-1:0]        row_pending;
    logic [NUM_BUTTONS-1:0] pending_rest;

    assign slot_free = !out_valid_reg || out_ready;

    // One row address per cycle for both row stores.
    always_comb
    begin
        if (state_reg == BK_DRAIN)
        begin
            rd_row = drain_idx_reg[BTN_W-1:PIN_W];
        end
        else
        begin
            case (head.cmd)
                CMD_PREPARE: rd_row = current_row_reg + ROW_W'(1);
                CMD_SAMPLE:  rd_row = current_row_reg - ROW_W'(1);
                default:     rd_row = head.row;
            endcase
        end
    end

    assign led_rd      = led_rows_reg[rd_row];
    assign btn_rd      = button_rows_reg[rd_row];
    assign row_pending = pending_reg[{rd_row, {PIN_W{1'b0}}} +: PINS]
                         ^ head.data ^ btn_rd;

    // Pending set with the bit under the drain pointer cleared.
    always_comb
    begin
        pending_rest                = pending_reg;
        pending_rest[drain_idx_reg] = 1'b0;
    end

    // Command execution and drain walk.
    always_comb
    begin
        state_next       = state_reg;
        current_row_next = current_row_reg;
        debounce_next    = debounce_reg;
        led_rows_next    = led_rows_reg;
        button_rows_next = button_rows_reg;
        pending_next     = pending_reg;
        drain_idx_next   = drain_idx_reg;
        pop              = 1'b0;
        load             = 1'b0;
        result           = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    unique case (head.cmd)
                        CMD_PREPARE:
                        begin
                            if (slot_free)
                            begin
                                pop                 = 1'b1;
                                load                = 1'b1;
                                current_row_next    = rd_row;
                                result.kind         = KIND_DRIVE;
                                result.rowsel_valid = cfg.rowsel_enable;
                                result.rowsel_byte  = ~(PINS'(1) << rd_row)
                                                      ^ cfg.rowsel_invert_mask;
                                result.column_valid = cfg.column_enable;
                                result.column_byte  = led_rd ^ cfg.column_invert_mask;
                                result.last         = 1'b1;
                            end
                        end
                        CMD_SAMPLE:
                        begin
                            pop = 1'b1;
                            if (cfg.button_enable)
                            begin
                                if (debounce_reg == '0)
                                begin
                                    pending_next[{rd_row, {PIN_W{1'b0}}} +: PINS] = row_pending;
                                    if (row_pending != '0)
                                    begin
                                        debounce_next = cfg.debounce_reload;
                                    end
                                    button_rows_next[rd_row] = head.data;
                                end
                                else
                                begin
                                    debounce_next = debounce_reg - 8'd1;
                                end
                            end
                        end
                        CMD_SET_LED:
                        begin
                            pop = 1'b1;
                            led_rows_next[rd_row] = head.bit_value ? (led_rd | head.data)
                                                                   : (led_rd & ~head.data);
                        end
                        CMD_WRITE_ROW:
                        begin
                            pop = 1'b1;
                            led_rows_next[rd_row] = head.data;
                        end
                        CMD_DRAIN:
                        begin
                            pop            = 1'b1;
                            state_next     = BK_DRAIN;
                            drain_idx_next = '0;
                        end
                        CMD_READ_ROW:
                        begin
                            if (slot_free)
                            begin
                                pop                   = 1'b1;
                                load                  = 1'b1;
                                result.kind           = KIND_READBACK;
                                result.button_row_out = btn_rd;
                                result.led_row_out    = led_rd;
                                result.last           = 1'b1;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_DRAIN:
            begin
                if (pending_reg == '0)
                begin
                    state_next = BK_IDLE;
                end
                else if (pending_reg[drain_idx_reg])
                begin
                    if (slot_free)
                    begin
                        load                 = 1'b1;
                        result.kind          = KIND_EVENT;
                        result.button_number = drain_idx_reg;
                        result.button_value  = btn_rd[drain_idx_reg[PIN_W-1:0]];
                        result.last          = (pending_rest == '0);
                        pending_next         = pending_rest;
                        drain_idx_next       = drain_idx_reg + BTN_W'(1);
                        if (pending_rest == '0)
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                end
                else
                begin
                    drain_idx_next = drain_idx_reg + BTN_W'(1);
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Matrix state and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            current_row_reg <= '0;
            debounce_reg    <= '0;
            pending_reg     <= '0;
            drain_idx_reg   <= '0;
            for (int r = 0; r < ROWS; r++)
            begin
                led_rows_reg[r]    <= '0;
                button_rows_reg[r] <= BUTTON_ROW_RESET;
            end
        end
        else
        begin
            state_reg       <= state_next;
            current_row_reg <= current_row_next;
            debounce_reg    <= debounce_next;
            pending_reg     <= pending_next;
            drain_idx_reg   <= drain_idx_next;
            led_rows_reg    <= led_rows_next;
            button_rows_reg <= button_rows_next;
        end
    end

    // Output register: holds a finished item until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A drain with nothing left pending returns to idle at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DRAIN && pending_reg == '0) |=> (state_reg == BK_IDLE))
        else $error("drain did not finish with nothing pending");

    // The final event of a drain leaves no pending bit behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && result.kind == KIND_EVENT && result.last) |=> (pending_reg == '0))
        else $error("pending bits remain after the final event");

    // No command is taken from the queue during a drain walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DRAIN) |-> !pop)
        else $error("command popped during drain");

    // An event is only produced for a bit that is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && result.kind == KIND_EVENT) |-> pending_reg[drain_idx_reg])
        else $error("event produced for a bit that is not pending");

endmodule

FILE: sv/button_led_matrix_scanner.sv
// A prepare or read-row result passes through the command queue and the output register.
// The back end runs one prepare, sample, LED write or read-row command per cycle; while the
// output is stalled, prepares, read-rows and drain events wait. A drain walks one button
// per cycle to the last pending one, while the two-entry command queue takes items.
// Reset (rst_n, asynchronous, active low) clears the configuration, LEDs, pending bits,
// row pointer and debounce counter, and sets every stored button row to all released.
module button_led_matrix_scanner #(
    parameter int QUEUE_DEPTH = blms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  blms_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output blms_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_wdata
);
    import blms_pkg::*;

    cfg_t      cfg_reg;
    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_empty;
    cmd_item_t push_data;
    cmd_item_t head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWSEL_ENABLE:      cfg_reg.rowsel_enable      <= cfg_wdata[0];
                CFG_COLUMN_ENABLE:      cfg_reg.column_enable      <= cfg_wdata[0];
                CFG_BUTTON_ENABLE:      cfg_reg.button_enable      <= cfg_wdata[0];
                CFG_ROWSEL_INVERT_MASK: cfg_reg.rowsel_invert_mask <= cfg_wdata;
                CFG_COLUMN_INVERT_MASK: cfg_reg.column_invert_mask <= cfg_wdata;
                CFG_DEBOUNCE_DELAY:     cfg_reg.debounce_reload    <= cfg_wdata;
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // Front end: accepts and decodes items.
    blms_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Command queue between front and back.
    blms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // Back end: matrix state, debounce and drain walk.
    blms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import blms_pkg::*;

    // Op codes the block does not define; it must drop such items silently.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Cycles to let the block settle after the last expected result.
    localparam int SETTLE_CYCLES = 20;
    localparam int ITEMS_PER_SETTING = 26;
    localparam int NUM_SETTINGS = 7;

    // One line of the directed script: a register write or an item.
    typedef struct {
        bit         is_reg;
        logic [2:0] reg_idx;
        logic [7:0] reg_val;
        in_item_t   item;
        bit         typed;
        out_item_t  want;
    } step_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_wdata = '0;

    // Shadow copy of the matrix state and the registers.
    cfg_t       shadow_cfg;
    logic [7:0] matrix_leds [ROWS];
    logic [7:0] matrix_buttons [ROWS];
    logic [7:0] matrix_changes [ROWS];
    logic [2:0] row_ptr;
    logic [7:0] debounce_left;

    out_item_t due_results[$];
    step_t     script[$];
    int        mismatches = 0;
    bit        calm = 1'b0;
    int        ready_hold;

    button_led_matrix_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the results of one accepted item and advance the shadow state.
    function automatic void predict_scan(in_item_t it);
        out_item_t  res;
        out_item_t  held;
        bit         have_held;
        logic [2:0] scanned;
        res = '0;
        held = '0;
        have_held = 1'b0;
        case (it.op)
            OP_PREPARE:
            begin
                row_ptr = row_ptr + 3'd1;
                res.kind = KIND_DRIVE;
                res.rowsel_valid = shadow_cfg.rowsel_enable;
                res.rowsel_byte = ~(8'd1 << row_ptr) ^ shadow_cfg.rowsel_invert_mask;
                res.column_valid = shadow_cfg.column_enable;
                res.column_byte = matrix_leds[row_ptr] ^ shadow_cfg.column_invert_mask;
                res.last = 1'b1;
                due_results.push_back(res);
            end
            OP_SAMPLE:
            begin
                // The sample belongs to the row selected one step earlier.
                scanned = row_ptr - 3'd1;
                if (shadow_cfg.button_enable)
                begin
                    if (debounce_left == 8'd0)
                    begin
                        matrix_changes[scanned] ^= it.din_byte ^ matrix_buttons[scanned];
                        if (matrix_changes[scanned] != 8'd0)
                            debounce_left = shadow_cfg.debounce_reload;
                        matrix_buttons[scanned] = it.din_byte;
                    end
                    else
                    begin
                        debounce_left = debounce_left - 8'd1;
                    end
                end
            end
            OP_SET_LED:
                matrix_leds[it.led_index[5:3]][it.led_index[2:0]] = it.led_value;
            OP_WRITE_ROW:
                matrix_leds[it.row_index] = it.row_byte;
            OP_DRAIN:
            begin
                // One event per pending bit; the final one carries the last flag.
                for (int r = 0; r < ROWS; r++)
                begin
                    for (int p = 0; p < PINS; p++)
                    begin
                        if (matrix_changes[r][p])
                        begin
                            if (have_held)
                                due_results.push_back(held);
                            held = '0;
                            held.kind = KIND_EVENT;
                            held.button_number = 6'(r * PINS + p);
                            held.button_value = matrix_buttons[r][p];
                            have_held = 1'b1;
                        end
                    end
                    matrix_changes[r] = 8'd0;
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    due_results.push_back(held);
                end
            end
            OP_READ_ROW:
            begin
                res.kind = KIND_READBACK;
                res.button_row_out = matrix_buttons[it.row_index];
                res.led_row_out = matrix_leds[it.row_index];
                res.last = 1'b1;
                due_results.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic step_t item_step(logic [2:0] op, logic [7:0] din, logic [5:0] led,
                                        logic lval, logic [2:0] row, logic [7:0] rbyte);
        step_t s;
        s.is_reg = 1'b0;
        s.reg_idx = '0;
        s.reg_val = '0;
        s.item.op = op;
        s.item.din_byte = din;
        s.item.led_index = led;
        s.item.led_value = lval;
        s.item.row_index = row;
        s.item.row_byte = rbyte;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic step_t reg_step(logic [2:0] idx, logic [7:0] val);
        step_t s;
        s = item_step(OP_PREPARE, '0, '0, 1'b0, '0, '0);
        s.is_reg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic step_t with_result(step_t s, out_item_t r);
        step_t t;
        t = s;
        t.typed = 1'b1;
        t.want = r;
        return t;
    endfunction

    function automatic out_item_t result_of(logic [1:0] kind, logic rsv, logic [7:0] rsb,
                                            logic cv, logic [7:0] cb, logic [5:0] bn,
                                            logic bv, logic [7:0] bro, logic [7:0] lro);
        out_item_t r;
        r.kind = kind;
        r.rowsel_valid = rsv;
        r.rowsel_byte = rsb;
        r.column_valid = cv;
        r.column_byte = cb;
        r.button_number = bn;
        r.button_value = bv;
        r.button_row_out = bro;
        r.led_row_out = lro;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one item, hold it until accepted, then predict its results.
    // A typed result, when given, replaces the predicted one.
    task automatic send_item(input in_item_t item, input bit typed, input out_item_t want);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_scan(item);
        if (typed)
        begin
            void'(due_results.pop_back());
            due_results.push_back(want);
        end
        @(negedge clk);
    endtask

    // Stop sending and let every expected result arrive, then let the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ROWSEL_ENABLE:      shadow_cfg.rowsel_enable = val[0];
            CFG_COLUMN_ENABLE:      shadow_cfg.column_enable = val[0];
            CFG_BUTTON_ENABLE:      shadow_cfg.button_enable = val[0];
            CFG_ROWSEL_INVERT_MASK: shadow_cfg.rowsel_invert_mask = val;
            CFG_COLUMN_INVERT_MASK: shadow_cfg.column_invert_mask = val;
            CFG_DEBOUNCE_DELAY:     shadow_cfg.debounce_reload = val;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Result side: random stall bursts, none once the run turns calm.
    always
    begin
        @(negedge clk);
        if (rst_n && !calm && $urandom_range(0, 7) == 0)
        begin
            ready_hold = $urandom_range(1, 10);
            out_ready <= 1'b0;
            repeat (ready_hold) @(negedge clk);
        end
        out_ready <= 1'b1;
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result item: %p", out_data);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("kind", want.kind, out_data.kind);
                check_field("rowsel_valid", want.rowsel_valid, out_data.rowsel_valid);
                check_field("rowsel_byte", want.rowsel_byte, out_data.rowsel_byte);
                check_field("column_valid", want.column_valid, out_data.column_valid);
                check_field("column_byte", want.column_byte, out_data.column_byte);
                check_field("button_number", want.button_number, out_data.button_number);
                check_field("button_value", want.button_value, out_data.button_value);
                check_field("button_row_out", want.button_row_out, out_data.button_row_out);
                check_field("led_row_out", want.led_row_out, out_data.led_row_out);
                check_field("last", want.last, out_data.last);
            end
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        in_item_t   item;
        logic [7:0] val;
        int         sel;
        int         counted;

        shadow_cfg = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            matrix_leds[r] = 8'h00;
            matrix_buttons[r] = BUTTON_ROW_RESET;
            matrix_changes[r] = 8'h00;
        end
        row_ptr = '0;
        debounce_left = '0;

        // Reset defaults: drive bytes, readback, ignored sample, empty drain, spare ops.
        script.push_back(with_result(item_step(OP_PREPARE, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00),
            result_of(KIND_DRIVE, 1'b0, 8'hFD, 1'b0, 8'h00, 6'd0, 1'b0, 8'h00, 8'h00)));
        script.push_back(with_result(item_step(OP_READ_ROW, 8'h00, 6'd0, 1'b0, 3'd7, 8'h00),
            result_of(KIND_READBACK, 1'b0, 8'h00, 1'b0, 8'h00, 6'd0, 1'b0, 8'hFF, 8'h00)));
        script.push_back(item_step(OP_SAMPLE, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(item_step(OP_DRAIN, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(item_step(OP_SPARE_6, 8'hFF, 6'd63, 1'b1, 3'd7, 8'hFF));
        script.push_back(item_step(OP_SPARE_7, 8'hFF, 6'd63, 1'b1, 3'd7, 8'hFF));

        // Everything enabled, both masks at all ones, no debounce.
        script.push_back(reg_step(CFG_ROWSEL_ENABLE, 8'h01));
        script.push_back(reg_step(CFG_COLUMN_ENABLE, 8'h01));
        script.push_back(reg_step(CFG_BUTTON_ENABLE, 8'h01));
        script.push_back(reg_step(CFG_ROWSEL_INVERT_MASK, 8'hFF));
        script.push_back(reg_step(CFG_COLUMN_INVERT_MASK, 8'hFF));
        script.push_back(reg_step(CFG_DEBOUNCE_DELAY, 8'h00));

        // LED writes at the index extremes, then drive bytes that show them.
        script.push_back(item_step(OP_WRITE_ROW, 8'h00, 6'd0, 1'b0, 3'd2, 8'hA5));
        script.push_back(item_step(OP_SET_LED, 8'h00, 6'd63, 1'b1, 3'd0, 8'h00));
        script.push_back(item_step(OP_SET_LED, 8'h00, 6'd0, 1'b1, 3'd0, 8'h00));
        script.push_back(item_step(OP_SET_LED, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(with_result(item_step(OP_PREPARE, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00),
            result_of(KIND_DRIVE, 1'b1, 8'h04, 1'b1, 8'h5A, 6'd0, 1'b0, 8'h00, 8'h00)));

        // A full row change, then a change that reverts before any drain.
        script.push_back(item_step(OP_SAMPLE, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(with_result(item_step(OP_READ_ROW, 8'h00, 6'd0, 1'b0, 3'd1, 8'h00),
            result_of(KIND_READBACK, 1'b0, 8'h00, 1'b0, 8'h00, 6'd0, 1'b0, 8'h00, 8'h00)));
        script.push_back(with_result(item_step(OP_PREPARE, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00),
            result_of(KIND_DRIVE, 1'b1, 8'h08, 1'b1, 8'hFF, 6'd0, 1'b0, 8'h00, 8'h00)));
        script.push_back(item_step(OP_SAMPLE, 8'h0F, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(item_step(OP_SAMPLE, 8'hFF, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(item_step(OP_DRAIN, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));

        // Step the row pointer until it wraps to row zero; then row 7 is scanned.
        for (int k = 0; k < 4; k++)
            script.push_back(item_step(OP_PREPARE, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(with_result(item_step(OP_PREPARE, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00),
            result_of(KIND_DRIVE, 1'b1, 8'h01, 1'b1, 8'hFF, 6'd0, 1'b0, 8'h00, 8'h00)));
        script.push_back(item_step(OP_SAMPLE, 8'h7E, 6'd0, 1'b0, 3'd0, 8'h00));

        // Debounce: a change reloads the counter and the next samples are dropped.
        script.push_back(reg_step(CFG_DEBOUNCE_DELAY, 8'h02));
        script.push_back(item_step(OP_SAMPLE, 8'h7F, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(item_step(OP_SAMPLE, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(item_step(OP_SAMPLE, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
        script.push_back(with_result(item_step(OP_DRAIN, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00),
            result_of(KIND_EVENT, 1'b0, 8'h00, 1'b0, 8'h00, 6'd63, 1'b0, 8'h00, 8'h00)));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                wait_drained();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
            begin
                send_item(script[i].item, script[i].typed, script[i].want);
            end
        end

        // Random scanning under a series of register settings, extremes first.
        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            wait_drained();
            if (ph == NUM_SETTINGS - 1)
                calm = 1'b1;
            for (int idx = 0; idx < 6; idx++)
            begin
                case (ph)
                    0: val = 8'h00;
                    1: val = (idx <= CFG_BUTTON_ENABLE) ? 8'h01 :
                             (idx == CFG_DEBOUNCE_DELAY) ? 8'h00 : 8'hFF;
                    2: val = (idx <= CFG_BUTTON_ENABLE) ? 8'h01 : 8'hFF;
                    3: val = (idx <= CFG_BUTTON_ENABLE) ? 8'h01 :
                             (idx == CFG_DEBOUNCE_DELAY) ? 8'($urandom_range(1, 3)) :
                             8'($urandom);
                    default:
                    begin
                        if (idx == CFG_BUTTON_ENABLE)
                            val = ($urandom_range(0, 3) != 0) ? 8'h01 : 8'h00;
                        else if (idx < CFG_BUTTON_ENABLE)
                            val = 8'($urandom_range(0, 1));
                        else if (idx == CFG_DEBOUNCE_DELAY)
                            val = 8'($urandom_range(0, 3));
                        else
                            val = 8'($urandom);
                    end
                endcase
                write_reg(3'(idx), val);
            end

            counted = 0;
            while (counted < ITEMS_PER_SETTING)
            begin
                // Mostly prepare and sample pairs, with drains, LED traffic and readback.
                sel = $urandom_range(0, 99);
                if (sel < 30)
                    item.op = OP_PREPARE;
                else if (sel < 60)
                    item.op = OP_SAMPLE;
                else if (sel < 70)
                    item.op = OP_DRAIN;
                else if (sel < 78)
                    item.op = OP_SET_LED;
                else if (sel < 85)
                    item.op = OP_WRITE_ROW;
                else if (sel < 96)
                    item.op = OP_READ_ROW;
                else if (sel < 98)
                    item.op = OP_SPARE_6;
                else
                    item.op = OP_SPARE_7;

                // Button bytes usually differ from the stored row in a single pin.
                if ($urandom_range(0, 3) == 0)
                    item.din_byte = 8'($urandom);
                else
                    item.din_byte = matrix_buttons[row_ptr - 3'd1] ^
                                    (8'd1 << $urandom_range(0, 7));
                item.led_index = 6'($urandom);
                item.led_value = 1'($urandom);
                item.row_index = 3'($urandom);
                item.row_byte  = 8'($urandom);

                counted++;
                send_item(item, 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
